// File: rtl/core/pyr_pkg.sv
// constants and types for the 2x2 box downsample block
// no dependencies; imported by pyramid_2x2_box_downsample

package pyr_pkg;

   // sizes of the pixel format and the line store
   localparam int PIXEL_BITS = 32;
   localparam int SUM_BITS   = PIXEL_BITS + 1;
   localparam int ACC_BITS   = PIXEL_BITS + 2;
   localparam int MAX_WIDTH  = 8192;
   localparam int MAX_HEIGHT = 8192;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int OUT_BITS   = 12;

   // configuration port
   localparam int CFG_BITS       = 14;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IN_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_IN_HEIGHT = CSR_INDEX_BITS'(1);

   // kind of averaging for an emitting item
   typedef enum logic [1:0] {
      AVG_QUAD  = 2'd0,
      AVG_VPAIR = 2'd1,
      AVG_HPAIR = 2'd2,
      AVG_COPY  = 2'd3
   } avg_kind_type;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef logic signed [SUM_BITS-1:0]   pair_sum_type;

   // control of the result stage
   typedef struct packed {
      logic                valid;
      avg_kind_type        kind;
      logic [OUT_BITS-1:0] col;
      logic [OUT_BITS-1:0] row;
      logic                done;
   } stage_ctrl_type;

   // clamp a written size into 2..max, kept as the last index (size - 1)
   function automatic logic [COL_BITS-1:0] size_to_last(input logic [CFG_BITS-1:0] v,
                                                        input int                  max_v);
      logic [CFG_BITS-1:0] c;
      c = v;
      if (v < CFG_BITS'(2)) begin
         c = CFG_BITS'(2);
      end else if (v > CFG_BITS'(max_v)) begin
         c = CFG_BITS'(max_v);
      end
      return COL_BITS'(c - CFG_BITS'(1));
   endfunction

endpackage

// File: rtl/core/pyramid_2x2_box_downsample.sv
// top level of the 2x2 box downsample for one image-pyramid level
// depends on pyr_pkg; holds the pair-sum line store as an internal memory

// Usage
//   req_*  : input pixels of one layer in raster order, valid/ready handshake.
//   rsp_*  : averaged pixels of the half-size layer with their column and row;
//            rsp_layer_done marks the last pixel of the reduced layer.
//   csr_*  : writes in_width (index 0) or in_height (index 1), clamped to
//            2..8192; a write restarts the layer. Write only while idle.
// Timing
//   An item enters every cycle unless rsp stalls. Pixels of even rows
//   (except the extra last row of an odd-height layer) and of even columns
//   (except the extra last column of an odd-width layer) give no item out.
//   Read data and result stage are registered, then added and shifted into the
//   output register. The single-port line store takes one access per item.
// Reset and stalls
//   Reset sets both sizes to 2 and clears position and pipeline. The line
//   store is not cleared: every entry is written on an even row before the
//   odd row below reads it. When rsp stalls, the result stage and then
//   req_ready hold; no item is dropped.

module pyramid_2x2_box_downsample (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pyr_pkg::PIXEL_BITS-1:0] req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pyr_pkg::PIXEL_BITS-1:0] rsp_pixel_out,
   output logic [pyr_pkg::OUT_BITS-1:0]        rsp_out_col,
   output logic [pyr_pkg::OUT_BITS-1:0]        rsp_out_row,
   output logic                                rsp_layer_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pyr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pyr_pkg::CFG_BITS-1:0]        csr_wdata
);
   import pyr_pkg::*;

   // configuration and position
   logic [COL_BITS-1:0] w_last_ff, w_last_in;
   logic [ROW_BITS-1:0] h_last_ff, h_last_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   pixel_type           held_ff, held_in;

   // line store
   pair_sum_type        line_mem [LINE_DEPTH];
   pair_sum_type        line_rd_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   pair_sum_type        mem_wdata;
   logic                mem_we;
   logic                mem_re;

   // pipeline
   stage_ctrl_type      s1_ff, s1_in;
   pair_sum_type        s1_sum_ff;
   logic                out_valid_ff, out_valid_in;
   pixel_type           out_pixel_ff;
   logic [OUT_BITS-1:0] out_col_ff;
   logic [OUT_BITS-1:0] out_row_ff;
   logic                out_done_ff;

   logic                req_fire;
   logic                csr_fire;
   logic                csr_hit;
   logic                s1_adv;
   logic                odd_col, odd_row, last_col, last_row;
   logic                emit;
   avg_kind_type        kind;
   pair_sum_type        px_ext;
   pair_sum_type        pair_sum;
   logic signed [ACC_BITS-1:0] acc;
   pixel_type           result;

   // handshakes
   assign s1_adv    = s1_ff.valid && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_ff.valid || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_hit   = csr_fire && ((csr_index == REG_IN_WIDTH) || (csr_index == REG_IN_HEIGHT));

   // position decode of the incoming item
   assign odd_col  = col_ff[0];
   assign odd_row  = row_ff[0];
   assign last_col = (col_ff == w_last_ff);
   assign last_row = (row_ff == h_last_ff);
   assign px_ext   = SUM_BITS'(req_pixel_in);
   assign pair_sum = SUM_BITS'(held_ff) + px_ext;

   // classify: what the item emits and how the line store is used
   always_comb begin
      emit      = 1'b0;
      kind      = AVG_COPY;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = pair_sum;
      priority if (!odd_row && last_row) begin
         if (odd_col) begin
            emit = 1'b1;
            kind = AVG_HPAIR;
         end else if (last_col) begin
            emit = 1'b1;
            kind = AVG_COPY;
         end
      end else if (!odd_row) begin
         if (odd_col) begin
            mem_we = req_fire;
         end else if (last_col) begin
            mem_we    = req_fire;
            mem_wdata = px_ext;
         end
      end else begin
         if (odd_col) begin
            emit   = 1'b1;
            kind   = AVG_QUAD;
            mem_re = req_fire;
         end else if (last_col) begin
            emit   = 1'b1;
            kind   = AVG_VPAIR;
            mem_re = req_fire;
         end
      end
   end

   assign mem_addr = col_ff[COL_BITS-1:1];

   // next position, held pixel and sizes
   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      if (csr_hit) begin
         if (csr_index == REG_IN_WIDTH) begin
            w_last_in = size_to_last(csr_wdata, MAX_WIDTH);
         end else begin
            h_last_in = ROW_BITS'(size_to_last(csr_wdata, MAX_HEIGHT));
         end
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end else if (req_fire) begin
         if (!odd_col) begin
            held_in = req_pixel_in;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // line store: one access per item, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         line_rd_ff <= line_mem[mem_addr];
      end
   end

   // result stage control
   always_comb begin
      s1_in = s1_ff;
      if (req_fire) begin
         s1_in.valid = emit;
         s1_in.kind  = kind;
         s1_in.col   = OUT_BITS'(col_ff >> 1);
         s1_in.row   = OUT_BITS'(row_ff >> 1);
         s1_in.done  = last_col && last_row;
      end else if (s1_adv) begin
         s1_in.valid = 1'b0;
      end
   end

   // add the stored pair sum for the vertical kinds, then shift by the count of pixels averaged (floor)
   assign acc = ACC_BITS'(line_rd_ff) + ACC_BITS'(s1_sum_ff);

   always_comb begin
      unique case (s1_ff.kind)
         AVG_QUAD:  result = acc[ACC_BITS-1:2];
         AVG_VPAIR: result = acc[PIXEL_BITS:1];
         AVG_HPAIR: result = s1_sum_ff[PIXEL_BITS:1];
         AVG_COPY:  result = s1_sum_ff[PIXEL_BITS-1:0];
         default:   result = s1_sum_ff[PIXEL_BITS-1:0];
      endcase
   end

   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= COL_BITS'(1);
         h_last_ff    <= ROW_BITS'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         s1_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         s1_ff        <= s1_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sum_ff <= ((kind == AVG_QUAD) || (kind == AVG_HPAIR)) ? pair_sum : px_ext;
      end
      if (s1_adv) begin
         out_pixel_ff <= result;
         out_col_ff   <= s1_ff.col;
         out_row_ff   <= s1_ff.row;
         out_done_ff  <= s1_ff.done;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_layer_done = out_done_ff;

`ifndef SYNTHESIS
   // position never passes the configured size
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= w_last_ff) && (row_ff <= h_last_ff))
      else $error("position beyond layer size");

   // a single port: never read and write in one cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("line store read and write in the same cycle");

   // a stalled result stage keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !s1_adv |=> s1_ff.valid)
      else $error("result stage lost an item");

   // the result stage fills only from an accepted item
   a_s1_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_ff.valid) |-> $past(req_fire))
      else $error("result stage loaded without input item");

   // a size write restarts the layer
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (col_ff == '0) && (row_ff == '0))
      else $error("layer not restarted after size write");
`endif

endmodule
